/* src/multi_slot_deadline_timer_table_defines.svh */
// ----------------------------------------------------------------------------
// Deadline timer table assertion macros
// Shared property forms for the timer table checks.
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_DEADLINE_TIMER_TABLE_DEFINES_SVH
`define MULTI_SLOT_DEADLINE_TIMER_TABLE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MDTT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define MDTT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* src/mdtt_pkg.sv */
// ----------------------------------------------------------------------------
// Deadline timer table package
// Sizes, operation and result codes, and the slot entry type.
// ----------------------------------------------------------------------------
package mdtt_pkg;

    localparam int SLOTS   = 32;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int MAX_RES = 32;
    localparam int NEXP_W  = $clog2(MAX_RES + 1);
    localparam int TIME_W  = 32;
    localparam int ID_W    = 8;
    localparam int SLOT_W  = 5;

    localparam logic [TIME_W-1:0] ALL_ONES = 32'hffff_ffff;

    typedef logic [1:0]       t_op;
    typedef logic [2:0]       t_kind;
    typedef logic [IDX_W-1:0] t_idx;

    localparam t_op OP_TICK    = 2'd0;
    localparam t_op OP_ADD     = 2'd1;
    localparam t_op OP_DELETE  = 2'd2;
    localparam t_op OP_PROCESS = 2'd3;

    localparam t_kind KIND_ADDED   = 3'd0;
    localparam t_kind KIND_FULL    = 3'd1;
    localparam t_kind KIND_EXPIRED = 3'd2;
    localparam t_kind KIND_TICK    = 3'd3;
    localparam t_kind KIND_DELETED = 3'd4;
    localparam t_kind KIND_NONE    = 3'd5;

    typedef struct packed {
        logic              active;
        logic [TIME_W-1:0] deadline;
    } t_slot;

endpackage

/* src/multi_slot_deadline_timer_table.sv */
// ----------------------------------------------------------------------------
// Multi-slot deadline timer table
// Tick count, ring of timer slots and earliest deadline, with add, delete
// and expiry scan operations.
// ----------------------------------------------------------------------------
//  channel  signals                              direction
//  in       i_in_valid / o_in_ready, op fields   into block
//  out      o_out_valid / i_out_ready, results   out of block
//
//  Tick, and a process item while the count is below the earliest deadline,
//  go from accept to the final state, which passes the result to the output
//  register once it is free. Add, delete and process rotate the slot ring
//  once past the head cell, one slot a cycle. A process item that expires
//  slots stalls the rotation while a result waits on the output register.
//  Reset clears every active bit at once; no clearing pass is run.
// ----------------------------------------------------------------------------
`include "multi_slot_deadline_timer_table_defines.svh"

module multi_slot_deadline_timer_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_operation,
    input  logic [mdtt_pkg::TIME_W-1:0]  i_timeout,
    input  logic [mdtt_pkg::ID_W-1:0]    i_slot_id,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [2:0]                   o_kind,
    output logic [mdtt_pkg::SLOT_W-1:0]  o_slot,
    output logic                         o_irq_pending,
    output logic [mdtt_pkg::TIME_W-1:0]  o_now_time,
    output logic                         o_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    localparam mdtt_pkg::t_idx IDX_LAST = mdtt_pkg::IDX_W'(mdtt_pkg::SLOTS - 1);

    logic [1:0]                        r_state;
    logic [mdtt_pkg::TIME_W-1:0]       r_now;
    logic [mdtt_pkg::TIME_W-1:0]       r_earliest;
    logic                              r_hold_valid;
    logic                              r_out_valid;

    mdtt_pkg::t_op                     r_op;
    logic [mdtt_pkg::TIME_W-1:0]       r_value;
    logic [mdtt_pkg::ID_W-1:0]         r_id;
    mdtt_pkg::t_idx                    r_idx;
    logic                              r_placed;
    mdtt_pkg::t_idx                    r_add_slot;
    logic [mdtt_pkg::TIME_W-1:0]       r_min;
    logic [mdtt_pkg::NEXP_W-1:0]       r_nexp;
    mdtt_pkg::t_idx                    r_hold_slot;

    mdtt_pkg::t_kind                   r_kind;
    logic [mdtt_pkg::SLOT_W-1:0]       r_slot;
    logic                              r_irq;
    logic [mdtt_pkg::TIME_W-1:0]       r_now_out;
    logic                              r_last;

    mdtt_pkg::t_slot                   w_head;
    mdtt_pkg::t_slot                   w_tail;
    logic                              w_in_acc;
    logic                              w_out_free;
    logic                              w_is_add;
    logic                              w_is_proc;
    logic                              w_due;
    logic                              w_take;
    logic                              w_del;
    logic                              w_step;
    logic                              w_last_step;
    logic                              w_push_part;
    logic                              w_push_fin;
    logic [mdtt_pkg::TIME_W-1:0]       w_min_next;
    mdtt_pkg::t_kind                   w_fin_kind;
    logic [mdtt_pkg::SLOT_W-1:0]       w_fin_slot;
    logic                              w_fin_irq;

    mdtt_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_step),
        .i_tail  (w_tail),
        .o_head  (w_head)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_is_add  = (r_op == mdtt_pkg::OP_ADD);
    assign w_is_proc = (r_op == mdtt_pkg::OP_PROCESS);

    // the expiry limit keeps later due slots active for the next process item
    assign w_due  = w_is_proc && w_head.active && (w_head.deadline <= r_now)
                    && (r_nexp < mdtt_pkg::NEXP_W'(mdtt_pkg::MAX_RES));
    assign w_take = w_is_add && !r_placed && !w_head.active;
    assign w_del  = (r_op == mdtt_pkg::OP_DELETE)
                    && (r_id == mdtt_pkg::ID_W'(r_idx));

    // hold the ring while a held expiry cannot be handed to the output
    assign w_step      = (r_state == S_SCAN) && !(w_due && r_hold_valid && !w_out_free);
    assign w_last_step = w_step && (r_idx == IDX_LAST);
    assign w_push_part = (r_state == S_SCAN) && w_due && r_hold_valid && w_out_free;
    assign w_push_fin  = (r_state == S_FIN) && w_out_free;

    always_comb begin
        w_tail = w_head;
        if (w_take) begin
            w_tail.active   = 1'b1;
            w_tail.deadline = r_value;
        end
        if (w_due || w_del) begin
            w_tail.active = 1'b0;
        end
    end

    assign w_min_next = (w_head.active && !w_due && (w_head.deadline < r_min))
                        ? w_head.deadline : r_min;

    always_comb begin
        w_fin_kind = mdtt_pkg::KIND_NONE;
        w_fin_slot = '0;
        w_fin_irq  = 1'b0;
        case (r_op)
            mdtt_pkg::OP_TICK: begin
                w_fin_kind = mdtt_pkg::KIND_TICK;
                w_fin_irq  = (r_now >= r_earliest);
            end
            mdtt_pkg::OP_ADD: begin
                if (r_placed) begin
                    w_fin_kind = mdtt_pkg::KIND_ADDED;
                    w_fin_slot = mdtt_pkg::SLOT_W'(r_add_slot);
                end else begin
                    w_fin_kind = mdtt_pkg::KIND_FULL;
                end
            end
            mdtt_pkg::OP_DELETE: begin
                w_fin_kind = mdtt_pkg::KIND_DELETED;
            end
            default: begin
                if (r_hold_valid) begin
                    w_fin_kind = mdtt_pkg::KIND_EXPIRED;
                    w_fin_slot = mdtt_pkg::SLOT_W'(r_hold_slot);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_now        <= '0;
            r_earliest   <= mdtt_pkg::ALL_ONES;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_push_part || w_push_fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_operation)
                            mdtt_pkg::OP_TICK: begin
                                r_now   <= r_now + 1'b1;
                                r_state <= S_FIN;
                            end
                            mdtt_pkg::OP_PROCESS: begin
                                r_state <= (r_now < r_earliest) ? S_FIN : S_SCAN;
                            end
                            default: begin
                                r_state <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (w_step) begin
                        if (w_due) begin
                            r_hold_valid <= 1'b1;
                        end
                        if (w_take && (r_value < r_earliest)) begin
                            r_earliest <= r_value;
                        end
                        if (w_last_step) begin
                            r_state <= S_FIN;
                            if (w_is_proc) begin
                                r_earliest <= w_min_next;
                            end
                        end
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_state      <= S_IDLE;
                        r_hold_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op     <= i_operation;
            r_value  <= r_now + i_timeout;
            r_id     <= i_slot_id;
            r_idx    <= '0;
            r_placed <= 1'b0;
            r_min    <= mdtt_pkg::ALL_ONES;
            r_nexp   <= '0;
        end else if (w_step) begin
            r_idx <= (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
            r_min <= w_min_next;
            if (w_take) begin
                r_placed   <= 1'b1;
                r_add_slot <= r_idx;
            end
            if (w_due) begin
                r_nexp      <= r_nexp + 1'b1;
                r_hold_slot <= r_idx;
            end
        end

        if (w_push_part) begin
            r_kind    <= mdtt_pkg::KIND_EXPIRED;
            r_slot    <= mdtt_pkg::SLOT_W'(r_hold_slot);
            r_irq     <= 1'b0;
            r_now_out <= r_now;
            r_last    <= 1'b0;
        end else if (w_push_fin) begin
            r_kind    <= w_fin_kind;
            r_slot    <= w_fin_slot;
            r_irq     <= w_fin_irq;
            r_now_out <= r_now;
            r_last    <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_slot        = r_slot;
    assign o_irq_pending = r_irq;
    assign o_now_time    = r_now_out;
    assign o_last        = r_last;

    `MDTT_ASSERT_NXT(a_ring_realigned, w_last_step, (r_idx == '0) && (r_state == S_FIN), "slot ring not back in order after a full rotation")
    `MDTT_ASSERT_IMP(a_hold_only_process, r_hold_valid, r_op == mdtt_pkg::OP_PROCESS, "held expiry outside a process item")
    `MDTT_ASSERT_IMP(a_idle_hold_empty, r_state == S_IDLE, !r_hold_valid, "held expiry left over when idle")
    `MDTT_ASSERT_IMP(a_partial_is_expiry, o_out_valid && !o_last, o_kind == mdtt_pkg::KIND_EXPIRED, "non-final result that is not an expiry")
    `MDTT_ASSERT_IMP(a_expiry_limit, r_state == S_SCAN, r_nexp <= mdtt_pkg::NEXP_W'(mdtt_pkg::MAX_RES), "too many expirations in one scan")

endmodule

/* src/mdtt_cell.sv */
// ----------------------------------------------------------------------------
// Timer slot cell
// Holds one slot entry and loads its neighbor's entry on each shift.
// ----------------------------------------------------------------------------
module mdtt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  mdtt_pkg::t_slot i_entry,
    output mdtt_pkg::t_slot o_entry
);

    logic                        r_active;
    logic [mdtt_pkg::TIME_W-1:0] r_deadline;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_shift) begin
            r_active <= i_entry.active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_deadline <= i_entry.deadline;
        end
    end

    assign o_entry.active   = r_active;
    assign o_entry.deadline = r_deadline;

endmodule

/* src/mdtt_ring.sv */
// ----------------------------------------------------------------------------
// Timer slot ring
// Row of slot cells; each shift moves every entry one cell toward the head
// and loads the tail with the entry updated at the head.
// ----------------------------------------------------------------------------
module mdtt_ring (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_shift,
    input  mdtt_pkg::t_slot i_tail,
    output mdtt_pkg::t_slot o_head
);

    mdtt_pkg::t_slot w_cell_out [mdtt_pkg::SLOTS];

    for (genvar k = 0; k < mdtt_pkg::SLOTS; k++) begin : g_cell
        mdtt_pkg::t_slot w_cell_in;

        if (k == mdtt_pkg::SLOTS - 1) begin : g_tail
            assign w_cell_in = i_tail;
        end else begin : g_body
            assign w_cell_in = w_cell_out[k+1];
        end

        mdtt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (i_shift),
            .i_entry (w_cell_in),
            .o_entry (w_cell_out[k])
        );
    end

    assign o_head = w_cell_out[0];

endmodule

/* sim/timer_table_checker.sv */
// ----------------------------------------------------------------------------
// Deadline timer table checker
// Watches both channels of the timer table, tracks the tick count, the slot
// table and the earliest deadline for every accepted item, and compares
// every accepted result with the oldest outstanding one.
// ----------------------------------------------------------------------------
module timer_table_checker
    import mdtt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [1:0]        i_operation,
    input  logic [TIME_W-1:0] i_timeout,
    input  logic [ID_W-1:0]   i_slot_id,
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic [2:0]        i_kind,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic              i_irq_pending,
    input  logic [TIME_W-1:0] i_now_time,
    input  logic              i_last,
    output int                o_mismatches,
    output int                o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_kind             kind;
        logic [SLOT_W-1:0] slot;
        logic              irq;
        logic [TIME_W-1:0] now;
        logic              last;
    } t_timer_result;

    logic [TIME_W-1:0] tick_count;
    logic              slot_busy     [SLOTS];
    logic [TIME_W-1:0] slot_deadline [SLOTS];
    logic [TIME_W-1:0] earliest;
    t_timer_result     timer_results_q [$];

    task automatic push_result(t_kind kind, int slot, logic irq, logic last);
        t_timer_result r;
        r.kind = kind;
        r.slot = SLOT_W'(slot);
        r.irq  = irq;
        r.now  = tick_count;
        r.last = last;
        timer_results_q.push_back(r);
    endtask

    task automatic run_timer_op(t_op op, logic [TIME_W-1:0] delay, logic [ID_W-1:0] id);
        int                i;
        int                n;
        logic              placed;
        logic [TIME_W-1:0] lowest;
        case (op)
            OP_TICK: begin
                tick_count = tick_count + 1'b1;
                push_result(KIND_TICK, 0, tick_count >= earliest, 1'b1);
            end
            OP_ADD: begin
                placed = 1'b0;
                for (i = 0; i < SLOTS; i++) begin
                    if (!placed && !slot_busy[i]) begin
                        placed           = 1'b1;
                        slot_busy[i]     = 1'b1;
                        slot_deadline[i] = tick_count + delay;
                        if (slot_deadline[i] < earliest)
                            earliest = slot_deadline[i];
                        push_result(KIND_ADDED, i, 1'b0, 1'b1);
                    end
                end
                if (!placed)
                    push_result(KIND_FULL, 0, 1'b0, 1'b1);
            end
            OP_DELETE: begin
                // out-of-range ids and the stale earliest deadline stay as they are
                if (id < SLOTS)
                    slot_busy[id] = 1'b0;
                push_result(KIND_DELETED, 0, 1'b0, 1'b1);
            end
            OP_PROCESS: begin
                if (tick_count < earliest) begin
                    push_result(KIND_NONE, 0, 1'b0, 1'b1);
                end else begin
                    n      = 0;
                    lowest = ALL_ONES;
                    for (i = 0; i < SLOTS; i++) begin
                        if (n < MAX_RES && slot_busy[i] && slot_deadline[i] <= tick_count) begin
                            slot_busy[i] = 1'b0;
                            push_result(KIND_EXPIRED, i, 1'b0, 1'b0);
                            n++;
                        end
                    end
                    for (i = 0; i < SLOTS; i++) begin
                        if (slot_busy[i] && slot_deadline[i] < lowest)
                            lowest = slot_deadline[i];
                    end
                    earliest = lowest;
                    if (n == 0)
                        push_result(KIND_NONE, 0, 1'b0, 1'b1);
                    else
                        timer_results_q[timer_results_q.size() - 1].last = 1'b1;
                end
            end
        endcase
    endtask

    task automatic log_mismatch(string what, t_timer_result want, t_timer_result got);
        o_mismatches++;
        if (o_mismatches <= 10)
            $display("%0t checker: %s: expected kind %0d slot %0d irq %0b now %0d last %0b, actual kind %0d slot %0d irq %0b now %0d last %0b",
                     $realtime, what, want.kind, want.slot, want.irq, want.now, want.last,
                     got.kind, got.slot, got.irq, got.now, got.last);
    endtask

    always @(posedge i_clk) begin : watch
        t_timer_result want;
        t_timer_result got;
        int            i;
        if (!i_rst_n) begin
            tick_count = '0;
            earliest   = ALL_ONES;
            for (i = 0; i < SLOTS; i++) begin
                slot_busy[i]     = 1'b0;
                slot_deadline[i] = '0;
            end
            timer_results_q.delete();
            o_mismatches = 0;
        end else begin
            if (i_in_valid && i_in_ready)
                run_timer_op(t_op'(i_operation), i_timeout, i_slot_id);
            if (i_out_valid && i_out_ready) begin
                got.kind = i_kind;
                got.slot = i_slot;
                got.irq  = i_irq_pending;
                got.now  = i_now_time;
                got.last = i_last;
                if (timer_results_q.size() == 0) begin
                    log_mismatch("result with nothing outstanding", '0, got);
                end else begin
                    want = timer_results_q.pop_front();
                    if (got.kind !== want.kind || got.slot !== want.slot
                        || got.irq !== want.irq || got.now !== want.now
                        || got.last !== want.last)
                        log_mismatch("result differs", want, got);
                end
            end
        end
        o_outstanding = timer_results_q.size();
    end

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// Deadline timer table testbench
// Drives directed and random tick, add, delete and process items through the
// timer table with random idling on both channels and one long output hold,
// and leaves all result checking to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mdtt_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 2 * (SLOTS + 2);
    localparam int ITEMS        = 180;
    localparam int DIRECTED     = 22;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        operation;
    logic [TIME_W-1:0] timeout;
    logic [ID_W-1:0]   slot_id;
    logic              out_valid;
    logic              out_ready;
    logic [2:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic              irq_pending;
    logic [TIME_W-1:0] now_time;
    logic              last;

    int mismatches;
    int outstanding;
    int sender_idle_pct;
    int receiver_stall_pct;
    int hold_requests;
    int items_sent;

    multi_slot_deadline_timer_table dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_operation   (operation),
        .i_timeout     (timeout),
        .i_slot_id     (slot_id),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_kind        (kind),
        .o_slot        (slot),
        .o_irq_pending (irq_pending),
        .o_now_time    (now_time),
        .o_last        (last)
    );

    timer_table_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_operation   (operation),
        .i_timeout     (timeout),
        .i_slot_id     (slot_id),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_kind        (kind),
        .i_slot        (slot),
        .i_irq_pending (irq_pending),
        .i_now_time    (now_time),
        .i_last        (last),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one item per call; valid stays up until the block takes it
    task automatic send_item(t_op op, logic [TIME_W-1:0] delay, logic [ID_W-1:0] id);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        operation = op;
        timeout   = delay;
        slot_id   = id;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic run_random_burst();
        int pick;
        int reps;
        pick = $urandom_range(0, 9);
        reps = $urandom_range(1, 6);
        case (pick)
            0, 1, 2:
                repeat (reps)
                    send_item(OP_ADD,
                              ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 8),
                              ID_W'($urandom));
            3, 4, 5:
                repeat (reps) send_item(OP_TICK, $urandom, ID_W'($urandom));
            6, 7:
                send_item(OP_PROCESS, $urandom, ID_W'($urandom));
            8:
                send_item(OP_DELETE, $urandom,
                          ($urandom_range(0, 1) == 1) ? ID_W'($urandom_range(0, SLOTS - 1))
                                                      : ID_W'($urandom_range(0, 255)));
            default:
                send_item(t_op'($urandom_range(0, 3)), $urandom, ID_W'($urandom));
        endcase
    endtask

    initial begin : receiver
        int hold_left;
        int served;
        out_ready = 1'b0;
        hold_left = 0;
        served    = 0;
        forever begin
            @(negedge clk);
            if (hold_left == 0 && served != hold_requests) begin
                served    = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_ready = 1'b0;
                hold_left--;
            end else begin
                out_ready = ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_top: errors");
        $finish;
    end

    initial begin : stimulus
        int phase;
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        operation          = OP_TICK;
        timeout            = '0;
        slot_id            = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_requests      = 0;
        items_sent         = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // process on an empty table, then two timers due at once, one wrapped
        send_item(OP_PROCESS, '0, '0);
        send_item(OP_TICK, ALL_ONES, 8'hff);
        send_item(OP_ADD, '0, '0);
        send_item(OP_ADD, ALL_ONES, '0);
        send_item(OP_TICK, '0, '0);
        send_item(OP_PROCESS, '0, '0);
        send_item(OP_PROCESS, '0, '0);
        // delete leaves the earliest deadline stale: process finds nothing due
        send_item(OP_ADD, 32'h8000_0000, '0);
        send_item(OP_ADD, 32'd3, '0);
        send_item(OP_DELETE, '0, 8'd1);
        repeat (3) send_item(OP_TICK, '0, '0);
        send_item(OP_PROCESS, '0, '0);
        // out-of-range ids, an active slot and a never-used id
        send_item(OP_DELETE, '0, 8'(SLOTS));
        send_item(OP_DELETE, '0, 8'hff);
        send_item(OP_DELETE, '0, 8'd0);
        send_item(OP_DELETE, '0, 8'(SLOTS - 1));
        send_item(OP_ADD, 32'h7fff_ffff, '0);
        send_item(OP_ADD, '0, '0);
        send_item(OP_TICK, '0, '0);
        send_item(OP_PROCESS, '0, '0);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 60; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 60; end
                default: begin sender_idle_pct = 30; receiver_stall_pct = 30; end
            endcase
            if (phase == 0) begin
                // fill past full, hold the output while ticks pile up, expire the new timers
                repeat (SLOTS + 1) send_item(OP_ADD, $urandom_range(0, 4), ID_W'($urandom));
                hold_requests++;
                repeat (12) send_item(OP_TICK, $urandom, ID_W'($urandom));
                send_item(OP_PROCESS, $urandom, ID_W'($urandom));
            end
            while (items_sent < DIRECTED + (phase + 1) * (ITEMS - DIRECTED) / 4)
                run_random_burst();
        end

        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
